// File: hdl/lwma3_pkg.sv
// ----------------------------------------------------------------------------
// lwma3_pkg
// Shared widths, register indexes and defaults for the LWMA-3 difficulty unit.
// ----------------------------------------------------------------------------
package lwma3_pkg;

  localparam int WORD_W         = 64;
  localparam int WS_W           = 10;
  localparam int BT_W           = 16;
  localparam int CFG_W          = 16;
  localparam int WINDOW_MAX_DEF = 1023;

  // config register indexes
  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic REG_BLOCK_TIME  = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

endpackage

// File: hdl/lwma3_div.sv
// ----------------------------------------------------------------------------
// lwma3_div
// Radix-2 restoring divider, one quotient bit per cycle. Divide by zero
// returns all ones.
// ----------------------------------------------------------------------------
module lwma3_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  lwma3_pkg::word_t dividend,
  input  lwma3_pkg::word_t divisor,
  output logic           busy,
  output logic           done,
  output lwma3_pkg::word_t quotient
);

  localparam int W  = lwma3_pkg::WORD_W;
  localparam int CW = $clog2(W);

  logic [W-1:0]  q;
  logic [W-1:0]  r;
  logic [W-1:0]  d;
  logic [CW-1:0] cnt;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          fits;

  assign shifted = {r, q[W-1]};
  assign diff    = shifted - {1'b0, d};
  assign fits    = (shifted >= {1'b0, d});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (busy) begin
      r <= fits ? diff[W-1:0] : shifted[W-1:0];
      q <= {q[W-2:0], fits};
    end
  end

  assign quotient = q;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without work");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held");
`endif

endmodule

// File: hdl/lwma3_difficulty_unit.sv
// ----------------------------------------------------------------------------
// lwma3_difficulty_unit
// LWMA-3 difficulty adjustment over a window of (timestamp, cum. difficulty).
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream carries one request per block: tdata = {cum_diff, timestamp}.
//   After n+1 requests, n being window_size clamped to [3, WINDOW_MAX], the block emits one next_difficulty on m_*.
//   cfg_we/cfg_addr/cfg_wdata write window_size (0) and block_time (1); write
//   only while idle.
// Timing:
//   A non-final request is accepted, then takes one step that does the
//   capped solve time and weighted accumulate. The final request of a
//   window runs a sequencer over a shared 64x17 shift-add multiplier
//   (seven products), a 64-bit restoring divider for the raw quotient and
//   three divides by 100 done a byte at a time by reciprocal multiply.
//   m_tvalid rises when the result register is loaded; s_tready returns on
//   the same edge.
//   s_tready is low while a request is being worked on.
// Reset (rst, sync):
//   clears the window position and sums; registers back to 60 / 120.
// Stall:
//   the result register holds until m_tready; a following window's result
//   waits in the sequencer until the register has been taken.
// ----------------------------------------------------------------------------
module lwma3_difficulty_unit #(
  parameter int WINDOW_MAX = lwma3_pkg::WINDOW_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [127:0]                s_tdata,   // [63:0] timestamp, [127:64] cumulative_difficulty
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [63:0]                 m_tdata,   // [63:0] next_difficulty
  input  logic                        cfg_we,
  input  logic                        cfg_addr,
  input  logic [lwma3_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int W    = lwma3_pkg::WORD_W;
  localparam int IW   = $clog2(WINDOW_MAX + 1);
  localparam int MB_W = 17;
  localparam int MC_W = 5;
  localparam int ST_W = 19;

  // floor(p / 100) = (p * RECIP_100) >> RECIP_SH for every p < 25600
  localparam int RECIP_100 = 20972;
  localparam int RECIP_SH  = 21;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_STEP   = 3'd1;
  localparam logic [2:0] S_LAUNCH = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;
  localparam logic [2:0] S_D100   = 3'd6;

  localparam logic [3:0] OP_NUM_T  = 4'd0;
  localparam logic [3:0] OP_NUM_N  = 4'd1;
  localparam logic [3:0] OP_NUM_99 = 4'd2;
  localparam logic [3:0] OP_DEN    = 4'd3;
  localparam logic [3:0] OP_RAW    = 4'd4;
  localparam logic [3:0] OP_LO_M   = 4'd5;
  localparam logic [3:0] OP_LO_D   = 4'd6;
  localparam logic [3:0] OP_HI_M   = 4'd7;
  localparam logic [3:0] OP_HI_D   = 4'd8;
  localparam logic [3:0] OP_UP_M   = 4'd9;
  localparam logic [3:0] OP_UP_D   = 4'd10;
  localparam logic [3:0] OP_DONE   = 4'd11;

  // config
  logic [lwma3_pkg::WS_W-1:0] window_size;
  logic [lwma3_pkg::BT_W-1:0] block_time;

  // window state
  logic [2:0]       state;
  logic [3:0]       op;
  logic [IW-1:0]    item_index;
  lwma3_pkg::word_t last_time;
  lwma3_pkg::word_t first_cum_diff;
  lwma3_pkg::word_t prior_cum_diff;
  lwma3_pkg::word_t weighted_sum;
  logic [23:0]      recent_sum;
  lwma3_pkg::word_t ts_r;
  lwma3_pkg::word_t cd_r;

  // final-stage results
  lwma3_pkg::word_t prod;
  lwma3_pkg::word_t num;
  lwma3_pkg::word_t raw;
  lwma3_pkg::word_t lo;
  lwma3_pkg::word_t hi;
  lwma3_pkg::word_t up;

  // shared multiplier
  lwma3_pkg::word_t mul_a;
  logic [MB_W-1:0]  mul_b;
  lwma3_pkg::word_t mul_acc;
  logic [MC_W-1:0]  mul_cnt;
  lwma3_pkg::word_t mul_sum;

  // divider hookup
  logic             div_start;
  lwma3_pkg::word_t div_a;
  lwma3_pkg::word_t div_b;
  logic             div_busy;
  logic             div_done;
  lwma3_pkg::word_t div_q;

  // divide by 100, one byte of dividend per cycle, MSB first
  lwma3_pkg::word_t d100_src;
  lwma3_pkg::word_t d100_q;
  lwma3_pkg::word_t d100_q_next;
  logic [6:0]       d100_rem;
  logic [6:0]       d100_rem_next;
  logic [2:0]       d100_cnt;
  logic [14:0]      d100_part;
  logic [29:0]      d100_prod;
  logic [7:0]       d100_digit;

  // output handshake
  logic             out_load;

  // effective window, clamped to [3, WINDOW_MAX]
  logic [31:0]   ws32;
  logic [31:0]   n32;
  logic [IW-1:0] n_eff;

  assign ws32  = 32'(window_size);
  assign n32   = (ws32 < 32'd3) ? 32'd3 :
                 (ws32 > 32'(WINDOW_MAX)) ? 32'(WINDOW_MAX) : ws32;
  assign n_eff = IW'(n32);

  // per-pair step
  lwma3_pkg::word_t next_time;
  lwma3_pkg::word_t solve_diff;
  logic [ST_W-1:0]  cap;
  logic [ST_W-1:0]  st;
  logic [ST_W+IW-1:0] st_w;

  assign next_time  = (ts_r > last_time) ? ts_r : last_time + 1'b1;
  assign solve_diff = next_time - last_time;
  assign cap        = ST_W'(block_time) * ST_W'(6);
  assign st         = (solve_diff < W'(cap)) ? solve_diff[ST_W-1:0] : cap;
  assign st_w       = (ST_W+IW)'(st) * (ST_W+IW)'(item_index);

  // fast-block test: recent < floor(9T/10)  <=>  10*(recent+1) <= 9T
  logic [28:0] recent_x10;
  logic [28:0] t_x9;
  logic        too_fast;
  assign recent_x10 = (29'(recent_sum) + 29'd1) * 29'd10;
  assign t_x9       = 29'(block_time) * 29'd9;
  assign too_fast   = (recent_x10 <= t_x9);

  lwma3_pkg::word_t clamp_mid;
  lwma3_pkg::word_t clamp_lo;
  lwma3_pkg::word_t result;
  assign clamp_mid = (raw < hi) ? raw : hi;
  assign clamp_lo  = (lo > clamp_mid) ? lo : clamp_mid;
  assign result    = (too_fast && up > clamp_lo) ? up : clamp_lo;

  assign mul_sum  = mul_acc + (mul_b[0] ? mul_a : '0);
  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  // remainder stays below 100, so each quotient digit fits in a byte
  assign d100_part     = {d100_rem, d100_src[W-1:W-8]};
  assign d100_prod     = 30'(d100_part) * 30'(RECIP_100);
  assign d100_digit    = d100_prod[RECIP_SH+7:RECIP_SH];
  assign d100_rem_next = 7'(d100_part - 15'(d100_digit) * 15'd100);
  assign d100_q_next   = {d100_q[W-9:0], d100_digit};

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= lwma3_pkg::WS_W'(60);
      block_time  <= lwma3_pkg::BT_W'(120);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lwma3_pkg::REG_WINDOW_SIZE: window_size <= cfg_wdata[lwma3_pkg::WS_W-1:0];
        lwma3_pkg::REG_BLOCK_TIME:  block_time  <= cfg_wdata;
      endcase
    end
  end

  // divider only produces the raw quotient num / den
  assign div_start = (state == S_LAUNCH) && (op == OP_RAW);
  assign div_a     = num;
  assign div_b     = prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      op             <= OP_NUM_T;
      item_index     <= '0;
      last_time      <= '0;
      first_cum_diff <= '0;
      prior_cum_diff <= '0;
      weighted_sum   <= '0;
      recent_sum     <= '0;
      m_tvalid       <= 1'b0;
      mul_cnt        <= '0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            ts_r  <= s_tdata[63:0];
            cd_r  <= s_tdata[127:64];
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (item_index == '0) begin
            last_time      <= ts_r;
            first_cum_diff <= cd_r;
            prior_cum_diff <= cd_r;
            weighted_sum   <= '0;
            recent_sum     <= '0;
            item_index     <= IW'(1);
            state          <= S_IDLE;
          end else begin
            last_time    <= next_time;
            weighted_sum <= weighted_sum + W'(st_w);
            if (item_index > n_eff - IW'(3)) recent_sum <= recent_sum + 24'(st);
            if (item_index < n_eff) begin
              prior_cum_diff <= cd_r;
              item_index     <= item_index + 1'b1;
              state          <= S_IDLE;
            end else begin
              item_index <= '0;
              op         <= OP_NUM_T;
              state      <= S_LAUNCH;
            end
          end
        end
        S_LAUNCH: begin
          mul_acc <= '0;
          mul_cnt <= '0;
          unique case (op)
            OP_NUM_T: begin
              mul_a <= cd_r - first_cum_diff;
              mul_b <= MB_W'(block_time);
              state <= S_MUL;
            end
            OP_NUM_N: begin
              mul_a <= prod;
              mul_b <= MB_W'(n_eff) + 1'b1;
              state <= S_MUL;
            end
            OP_NUM_99: begin
              mul_a <= prod;
              mul_b <= MB_W'(99);
              state <= S_MUL;
            end
            OP_DEN: begin
              mul_a <= weighted_sum;
              mul_b <= MB_W'(200);
              state <= S_MUL;
            end
            OP_LO_M: begin
              mul_a <= cd_r - prior_cum_diff;
              mul_b <= MB_W'(67);
              state <= S_MUL;
            end
            OP_HI_M: begin
              mul_a <= cd_r - prior_cum_diff;
              mul_b <= MB_W'(150);
              state <= S_MUL;
            end
            OP_UP_M: begin
              mul_a <= cd_r - prior_cum_diff;
              mul_b <= MB_W'(108);
              state <= S_MUL;
            end
            OP_RAW: state <= S_DIV;
            OP_LO_D, OP_HI_D, OP_UP_D: begin
              d100_src <= prod;
              d100_rem <= '0;
              d100_q   <= '0;
              d100_cnt <= '0;
              state    <= S_D100;
            end
            default: state <= S_OUT;
          endcase
        end
        S_MUL: begin
          mul_acc <= mul_sum;
          mul_a   <= {mul_a[W-2:0], 1'b0};
          mul_b   <= {1'b0, mul_b[MB_W-1:1]};
          mul_cnt <= mul_cnt + 1'b1;
          if (mul_cnt == MC_W'(MB_W - 1)) begin
            prod <= mul_sum;
            if (op == OP_NUM_99) num <= mul_sum;
            op    <= op + 1'b1;
            state <= S_LAUNCH;
          end
        end
        S_DIV: begin
          if (div_done) begin
            raw   <= div_q;
            op    <= op + 1'b1;
            state <= S_LAUNCH;
          end
        end
        S_D100: begin
          d100_src <= {d100_src[W-9:0], 8'd0};
          d100_rem <= d100_rem_next;
          d100_q   <= d100_q_next;
          d100_cnt <= d100_cnt + 1'b1;
          if (d100_cnt == 3'd7) begin
            unique case (op)
              OP_LO_D: lo <= d100_q_next;
              OP_HI_D: hi <= d100_q_next;
              default: up <= d100_q_next;
            endcase
            op    <= op + 1'b1;
            state <= S_LAUNCH;
          end
        end
        S_OUT: begin
          if (out_load) begin
            m_tdata <= result;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  lwma3_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> !s_tready)
    else $error("input ready while dividing");
  a_mul_div_excl: assert property (@(posedge clk) disable iff (rst)
    !(state == S_MUL && div_busy))
    else $error("multiplier and divider active together");
  a_out_after_ops: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> op == OP_DONE)
    else $error("result stage before sequence end");
`endif

endmodule
